[rtl/core/fbxf_pkg.sv]
// Package for the fountain block XOR / FNV sink.
// Holds the field widths, opcodes, FNV constants and parameter defaults.
// No dependencies.
package fbxf_pkg;

    localparam int OPCODE_W    = 2;
    localparam int OPERAND_W   = 9;
    localparam int BYTE_W      = 8;
    localparam int POS_W       = 32;
    localparam int HASH_W      = 32;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = HASH_W + BYTE_W + POS_W;

    localparam int BLOCK_BYTES_DEF = 64;
    localparam int MAX_DEGREE_DEF  = 16;
    localparam int MAX_BLOCKS_DEF  = 512;

    localparam logic [HASH_W-1:0] FNV_BASIS = 32'h811C_9DC5;
    localparam logic [HASH_W-1:0] FNV_PRIME = 32'h0100_0193;

    typedef enum logic [OPCODE_W-1:0] {
        OP_START  = 2'd0,
        OP_APPEND = 2'd1,
        OP_DATA   = 2'd2,
        OP_READ   = 2'd3
    } t_opcode;

    typedef struct packed {
        logic clr;
        logic adv;
    } t_pos_ctrl;

endpackage

[rtl/core/fountain_block_xor_fnv_sink.sv]
// Top level of the fountain block XOR / FNV-1a sink.
// Start clears the accumulator in S_CLEAR; append and a hash-mode byte go to S_DONE; read
// passes S_RDWAIT; an XOR-mode byte passes S_SCAN; one item in flight at a time. The
// accumulator and selected-list memories each take one read per cycle. Reset is
// synchronous, active low; after reset a clearing pass over all BLOCK_BYTES accumulator
// entries runs before the first item is taken. Depends on fbxf_pkg and fbxf_stream_pos.
module fountain_block_xor_fnv_sink #(
    parameter int BLOCK_BYTES = fbxf_pkg::BLOCK_BYTES_DEF,
    parameter int MAX_DEGREE  = fbxf_pkg::MAX_DEGREE_DEF,
    parameter int MAX_BLOCKS  = fbxf_pkg::MAX_BLOCKS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic                           i_cfg_wr_data,    // sink_mode
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [fbxf_pkg::S_TDATA_W-1:0] i_s_tdata,        // operand[8:0], zero pad
    input  logic [fbxf_pkg::OPCODE_W-1:0]  i_s_tuser,        // opcode[1:0]
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [fbxf_pkg::M_TDATA_W-1:0] o_m_tdata         // hash_value[31:0],
                                                             // block_byte[39:32],
                                                             // byte_position[71:40]
);
    import fbxf_pkg::*;

    localparam int ACC_AW  = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
    localparam int LIST_AW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int LEN_W   = $clog2(MAX_DEGREE + 1);
    localparam logic [ACC_AW-1:0] ACC_LAST = ACC_AW'(BLOCK_BYTES - 1);
    localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(MAX_DEGREE);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_RDWAIT = 5'b00100,
        S_CLEAR  = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state                 r_state, n_state;
    logic                   r_mode;
    logic [HASH_W-1:0]      r_hash, n_hash;
    logic [LEN_W-1:0]       r_len, n_len;
    logic [LEN_W-1:0]       r_cursor, n_cursor;
    logic [OPERAND_W-1:0]   r_operand;
    logic [BYTE_W-1:0]      r_byte, n_byte;
    logic [ACC_AW-1:0]      r_clr_addr, n_clr_addr;
    logic                   r_boot, n_boot;
    logic                   r_out_valid;
    logic [M_TDATA_W-1:0]   r_out_data;

    logic [OPERAND_W-1:0]   list_mem [MAX_DEGREE];
    logic [OPERAND_W-1:0]   r_list_q;
    logic [BYTE_W-1:0]      acc_mem [BLOCK_BYTES];
    logic [BYTE_W-1:0]      r_acc_q;

    t_opcode                in_op;
    logic [OPERAND_W-1:0]   in_operand;
    logic                   in_accept;
    logic                   out_load;
    t_pos_ctrl              pos_ctrl;
    logic [POS_W-1:0]       pos;
    logic [ACC_AW-1:0]      off;
    logic [POS_W-1:0]       blk;
    logic                   list_we;
    logic [LIST_AW-1:0]     list_ra;
    logic                   acc_we;
    logic [ACC_AW-1:0]      acc_wa;
    logic [BYTE_W-1:0]      acc_wd;
    logic [ACC_AW-1:0]      acc_ra;
    logic                   cur_live;

    assign in_op      = t_opcode'(i_s_tuser);
    assign in_operand = i_s_tdata[OPERAND_W-1:0];
    assign o_s_tready = (r_state == S_IDLE);
    assign in_accept  = i_s_tvalid && o_s_tready;
    assign cur_live   = (r_cursor < r_len);
    assign list_ra    = n_cursor[LIST_AW-1:0];
    assign acc_ra     = ((r_state == S_IDLE) && (in_op == OP_READ)) ? ACC_AW'(in_operand) : off;

    fbxf_stream_pos #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .ACC_AW      (ACC_AW)
    ) u_pos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (pos_ctrl),
        .o_pos   (pos),
        .o_off   (off),
        .o_blk   (blk)
    );

    always_comb begin
        n_state    = r_state;
        n_hash     = r_hash;
        n_len      = r_len;
        n_cursor   = r_cursor;
        n_byte     = r_byte;
        n_clr_addr = r_clr_addr;
        n_boot     = r_boot;
        pos_ctrl   = '0;
        list_we    = 1'b0;
        acc_we     = 1'b0;
        acc_wa     = off;
        acc_wd     = r_acc_q ^ r_operand[BYTE_W-1:0];
        out_load   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_byte = '0;
                    unique case (in_op)
                        OP_START: begin
                            n_hash       = FNV_BASIS;
                            n_len        = '0;
                            n_cursor     = '0;
                            n_clr_addr   = '0;
                            n_boot       = 1'b0;
                            pos_ctrl.clr = 1'b1;
                            n_state      = S_CLEAR;
                        end
                        OP_APPEND: begin
                            if ((r_len < LEN_MAX) && (32'(in_operand) < 32'(MAX_BLOCKS))) begin
                                list_we = 1'b1;
                                n_len   = r_len + LEN_W'(1);
                            end
                            n_state = S_DONE;
                        end
                        OP_DATA: begin
                            if (!r_mode) begin
                                n_hash = (r_hash ^ HASH_W'(in_operand[BYTE_W-1:0])) * FNV_PRIME;
                                pos_ctrl.adv = 1'b1;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_READ: begin
                            n_state = S_RDWAIT;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (cur_live && (32'(r_list_q) < blk)) begin
                    n_cursor = r_cursor + LEN_W'(1);
                end else begin
                    acc_we       = cur_live && (32'(r_list_q) == blk);
                    pos_ctrl.adv = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_RDWAIT: begin
                n_byte  = (32'(r_operand) < 32'(BLOCK_BYTES)) ? r_acc_q : '0;
                n_state = S_DONE;
            end
            S_CLEAR: begin
                acc_we = 1'b1;
                acc_wa = r_clr_addr;
                acc_wd = '0;
                if (r_clr_addr == ACC_LAST) begin
                    n_boot  = 1'b0;
                    n_state = r_boot ? S_IDLE : S_DONE;
                end else begin
                    n_clr_addr = r_clr_addr + ACC_AW'(1);
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_mode      <= 1'b0;
            r_hash      <= FNV_BASIS;
            r_len       <= '0;
            r_cursor    <= '0;
            r_clr_addr  <= '0;
            r_boot      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_hash     <= n_hash;
            r_len      <= n_len;
            r_cursor   <= n_cursor;
            r_clr_addr <= n_clr_addr;
            r_boot     <= n_boot;
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        if (in_accept) begin
            r_operand <= in_operand;
        end
        if (out_load) begin
            r_out_data <= {pos, r_byte, r_hash};
        end
    end

    always_ff @(posedge i_clk) begin
        if (list_we) begin
            list_mem[r_len[LIST_AW-1:0]] <= in_operand;
        end
        r_list_q <= list_mem[list_ra];
    end

    always_ff @(posedge i_clk) begin
        if (acc_we) begin
            acc_mem[acc_wa] <= acc_wd;
        end
        r_acc_q <= acc_mem[acc_ra];
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_MAX)
        else $error("selected list length exceeds capacity");

    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= r_len)
        else $error("list cursor passed the list length");

    a_acc_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_we |-> ((r_state == S_SCAN) || (r_state == S_CLEAR)))
        else $error("accumulator written outside scan or clear");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (in_op == OP_START)) |=> ((r_state == S_CLEAR) && (pos == '0)))
        else $error("start item did not begin the clearing pass");
`endif

endmodule

[rtl/core/fbxf_stream_pos.sv]
// Stream position tracker: byte count, offset within a block and block number.
// Depends on fbxf_pkg.
module fbxf_stream_pos #(
    parameter int BLOCK_BYTES = fbxf_pkg::BLOCK_BYTES_DEF,
    parameter int ACC_AW      = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  fbxf_pkg::t_pos_ctrl        i_ctrl,
    output logic [fbxf_pkg::POS_W-1:0] o_pos,
    output logic [ACC_AW-1:0]          o_off,
    output logic [fbxf_pkg::POS_W-1:0] o_blk
);
    import fbxf_pkg::*;

    localparam logic [ACC_AW-1:0] OFF_LAST = ACC_AW'(BLOCK_BYTES - 1);

    logic [POS_W-1:0]  r_pos;
    logic [ACC_AW-1:0] r_off;
    logic [POS_W-1:0]  r_blk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clr) begin
            r_pos <= '0;
            r_off <= '0;
            r_blk <= '0;
        end else if (i_ctrl.adv) begin
            r_pos <= r_pos + POS_W'(1);
            if (r_pos == {POS_W{1'b1}}) begin
                r_off <= '0;
                r_blk <= '0;
            end else if (r_off == OFF_LAST) begin
                r_off <= '0;
                r_blk <= r_blk + POS_W'(1);
            end else begin
                r_off <= r_off + ACC_AW'(1);
            end
        end
    end

    assign o_pos = r_pos;
    assign o_off = r_off;
    assign o_blk = r_blk;

endmodule
